### design/sct_pkg.sv
package sct_pkg;

  localparam int PosBits  = 32;
  localparam int NestBits = 8;

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [NestBits-1:0] nest_t;

  localparam nest_t NestMax = {NestBits{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_SHIFT, M_IDENT, M_NUM, M_STR, M_ESC, M_LINE,
    M_BLOCK, M_BSTAR, M_BSLASH, M_ERROR, M_DONE
  } mode_t;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrUnknown = 2'd1;
  localparam logic [1:0] ErrString  = 2'd2;
  localparam logic [1:0] ErrComment = 2'd3;

  localparam logic [5:0] KindEof    = 6'd0;
  localparam logic [5:0] KindShl    = 6'd45;
  localparam logic [5:0] KindShlEq  = 6'd47;
  localparam logic [5:0] KindShr    = 6'd49;
  localparam logic [5:0] KindShrEq  = 6'd51;
  localparam logic [5:0] KindSqStr  = 6'd52;
  localparam logic [5:0] KindDqStr  = 6'd53;
  localparam logic [5:0] KindIdent  = 6'd54;
  localparam logic [5:0] KindNumber = 6'd55;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [31:0] len;
  } tok_t;

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    case (p)
      8'h3a: single_kind = 6'd13; 8'h2a: single_kind = 6'd15;
      8'h2b: single_kind = 6'd17; 8'h2d: single_kind = 6'd20;
      8'h21: single_kind = 6'd24; 8'h7c: single_kind = 6'd26;
      8'h26: single_kind = 6'd29; 8'h5e: single_kind = 6'd32;
      8'h7e: single_kind = 6'd35; 8'h3d: single_kind = 6'd37;
      8'h2f: single_kind = 6'd40; 8'h25: single_kind = 6'd42;
      8'h3c: single_kind = 6'd44; 8'h3e: single_kind = 6'd48;
      default: single_kind = 6'd0;
    endcase
  endfunction

  // zero means no pair
  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    pair_kind = 6'd0;
    if (c == 8'h3d) begin
      case (p)
        8'h2a: pair_kind = 6'd16; 8'h2b: pair_kind = 6'd19;
        8'h2d: pair_kind = 6'd22; 8'h21: pair_kind = 6'd25;
        8'h7c: pair_kind = 6'd28; 8'h26: pair_kind = 6'd31;
        8'h5e: pair_kind = 6'd34; 8'h7e: pair_kind = 6'd36;
        8'h3d: pair_kind = 6'd38; 8'h2f: pair_kind = 6'd41;
        8'h25: pair_kind = 6'd43; 8'h3c: pair_kind = 6'd46;
        8'h3e: pair_kind = 6'd50;
        default: pair_kind = 6'd0;
      endcase
    end else if (p == 8'h3a && c == 8'h3a) pair_kind = 6'd14;
    else if (p == 8'h2b && c == 8'h2b) pair_kind = 6'd18;
    else if (p == 8'h2d && c == 8'h2d) pair_kind = 6'd21;
    else if (p == 8'h2d && c == 8'h3e) pair_kind = 6'd23;
    else if (p == 8'h7c && c == 8'h7c) pair_kind = 6'd27;
    else if (p == 8'h26 && c == 8'h26) pair_kind = 6'd30;
    else if (p == 8'h5e && c == 8'h5e) pair_kind = 6'd33;
    else if (p == 8'h3d && c == 8'h3e) pair_kind = 6'd39;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h24: punct_kind = 6'd1;  8'h28: punct_kind = 6'd2;
      8'h29: punct_kind = 6'd3;  8'h7b: punct_kind = 6'd4;
      8'h7d: punct_kind = 6'd5;  8'h5b: punct_kind = 6'd6;
      8'h5d: punct_kind = 6'd7;  8'h23: punct_kind = 6'd8;
      8'h40: punct_kind = 6'd9;  8'h2c: punct_kind = 6'd10;
      8'h3b: punct_kind = 6'd11; 8'h2e: punct_kind = 6'd12;
      default: punct_kind = 6'd0;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [31:0] out32(input pos_t v);
    if (PosBits >= 32) out32 = v[31:0];
    else out32 = 32'(v);
  endfunction

endpackage

### design/sct_out_queue.sv
// four-entry result queue with a one-bit last flag, ready whenever it can take a pair
module sct_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    push_n,
  input  sct_pkg::tok_t push_a,
  input  sct_pkg::tok_t push_b,
  output logic          room,
  output logic          head_valid,
  output sct_pkg::tok_t head,
  output logic          head_last,
  input  logic          pop
);
  sct_pkg::tok_t q0, q1, q2, q3;
  logic l0, l1, l2, l3;
  logic [2:0] count;
  logic [2:0] count_next;
  sct_pkg::tok_t s0, s1, s2, s3;
  logic t0, t1, t2, t3;
  logic [2:0] cnt_pop;

  assign head_valid = count != 3'd0;
  assign head = q0;
  assign head_last = l0;
  // room for two more even if nothing leaves
  assign room = count <= 3'd2;

  always_comb begin
    s0 = q0; s1 = q1; s2 = q2; s3 = q3;
    t0 = l0; t1 = l1; t2 = l2; t3 = l3;
    cnt_pop = count;
    if (pop && count != 3'd0) begin
      s0 = q1; s1 = q2; s2 = q3;
      t0 = l1; t1 = l2; t2 = l3;
      cnt_pop = count - 3'd1;
    end
    if (push && push_n != 2'd0) begin
      case (cnt_pop)
        3'd0: begin s0 = push_a; t0 = push_n == 2'd1; s1 = push_b; t1 = 1'b1; end
        3'd1: begin s1 = push_a; t1 = push_n == 2'd1; s2 = push_b; t2 = 1'b1; end
        default: begin s2 = push_a; t2 = push_n == 2'd1; s3 = push_b; t3 = 1'b1; end
      endcase
    end
    count_next = cnt_pop + ((push) ? {1'b0, push_n} : 3'd0);
  end

  always_ff @(posedge clk) begin
    q0 <= s0; q1 <= s1; q2 <= s2; q3 <= s3;
    l0 <= t0; l1 <= t1; l2 <= t2; l3 <= t3;
    if (rst) count <= 3'd0;
    else count <= count_next;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4) else $error("queue count out of range");
  a_pop_drops: assert property (@(posedge clk) disable iff (rst)
    (pop && head_valid && !push) |=> count == $past(count) - 3'd1)
    else $error("pop without count drop");
`endif
endmodule

### design/source_code_tokenizer_top.sv
// source code tokenizer: one source byte per input transfer, tokens out
// input channel: byte_value, end_of_input with in_valid / in_stall
//   a zero byte or end_of_input ends the text
// output channel: token_kind, error_code, token_start, token_length,
//   last_of_run with out_valid / out_stall
// each byte causes zero, one or two tokens; last_of_run marks the final
//   token of a byte's group
// throughput: one byte per cycle while in_stall is low; the scan state update is combinational
// a token is pushed into the queue when the byte that completes it is
//   transferred, and reaches the outputs from the queue's head register
// when the receiver stalls, tokens collect in a four-entry queue; input is
//   stalled once fewer than two free entries remain
// reset (rst, synchronous) returns to scanning between tokens at offset zero
//   and empties the queue
// after an error or the end token the block takes bytes but stays silent
//   until reset
module source_code_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [31:0] token_start,
  output logic [31:0] token_length,
  output logic        last_of_run
);
  sct_pkg::mode_t mode, mode_next;
  logic [7:0]     prefix, prefix_next;
  sct_pkg::pos_t  tbegin, tbegin_next;
  sct_pkg::pos_t  bpos;
  sct_pkg::nest_t depth, depth_next;
  sct_pkg::pos_t  cbegin, cbegin_next;

  logic room, take;
  logic [1:0] n_emit;
  sct_pkg::tok_t e_a, e_b;
  sct_pkg::tok_t head;

  assign in_stall = !room;
  assign take = in_valid && room;

  // scan state update and token formation for one byte
  always_comb begin
    logic [7:0] c;
    logic [5:0] k;
    logic run_idle;
    logic is_end;
    sct_pkg::tok_t t;
    c = byte_value;
    is_end = end_of_input || c == 8'd0;
    mode_next = mode;
    prefix_next = prefix;
    tbegin_next = tbegin;
    depth_next = depth;
    cbegin_next = cbegin;
    n_emit = 2'd0;
    e_a = '0;
    e_b = '0;
    run_idle = 1'b0;
    t = '0;
    k = 6'd0;
    if (mode == sct_pkg::M_ERROR || mode == sct_pkg::M_DONE) begin
      // silent
    end else if (is_end) begin
      run_idle = 1'b0;
      case (mode)
        sct_pkg::M_OP: begin
          e_a = '{sct_pkg::single_kind(prefix), sct_pkg::ErrNone,
                  sct_pkg::out32(tbegin), 32'd1};
          n_emit = 2'd1;
        end
        sct_pkg::M_SHIFT: begin
          e_a = '{(prefix == 8'h3c) ? sct_pkg::KindShl : sct_pkg::KindShr,
                  sct_pkg::ErrNone, sct_pkg::out32(tbegin), 32'd2};
          n_emit = 2'd1;
        end
        sct_pkg::M_IDENT, sct_pkg::M_NUM: begin
          e_a = '{(mode == sct_pkg::M_IDENT) ? sct_pkg::KindIdent : sct_pkg::KindNumber,
                  sct_pkg::ErrNone, sct_pkg::out32(tbegin), sct_pkg::out32(bpos - tbegin)};
          n_emit = 2'd1;
        end
        default: ;
      endcase
      if (mode == sct_pkg::M_STR || mode == sct_pkg::M_ESC) begin
        e_a = '{sct_pkg::KindEof, sct_pkg::ErrString, sct_pkg::out32(tbegin),
                sct_pkg::out32(bpos - tbegin)};
        n_emit = 2'd1;
        mode_next = sct_pkg::M_ERROR;
      end else if (mode == sct_pkg::M_BLOCK || mode == sct_pkg::M_BSTAR ||
                   mode == sct_pkg::M_BSLASH) begin
        e_a = '{sct_pkg::KindEof, sct_pkg::ErrComment, sct_pkg::out32(cbegin),
                sct_pkg::out32(bpos - cbegin)};
        n_emit = 2'd1;
        mode_next = sct_pkg::M_ERROR;
      end else begin
        t = '{sct_pkg::KindEof, sct_pkg::ErrNone, sct_pkg::out32(bpos), 32'd0};
        if (n_emit == 2'd0) e_a = t;
        else e_b = t;
        n_emit = n_emit + 2'd1;
        mode_next = sct_pkg::M_DONE;
      end
    end else begin
      case (mode)
        sct_pkg::M_IDLE: run_idle = 1'b1;
        sct_pkg::M_OP: begin
          k = sct_pkg::pair_kind(prefix, c);
          if (prefix == 8'h2f && c == 8'h2f) mode_next = sct_pkg::M_LINE;
          else if (prefix == 8'h2f && c == 8'h2a) begin
            mode_next = sct_pkg::M_BLOCK;
            depth_next = sct_pkg::nest_t'(1);
            cbegin_next = tbegin;
          end else if ((prefix == 8'h3c || prefix == 8'h3e) && c == prefix)
            mode_next = sct_pkg::M_SHIFT;
          else if (k != 6'd0) begin
            e_a = '{k, sct_pkg::ErrNone, sct_pkg::out32(tbegin), 32'd2};
            n_emit = 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end else begin
            e_a = '{sct_pkg::single_kind(prefix), sct_pkg::ErrNone,
                    sct_pkg::out32(tbegin), 32'd1};
            n_emit = 2'd1;
            run_idle = 1'b1;
          end
        end
        sct_pkg::M_SHIFT: begin
          if (c == 8'h3d) begin
            e_a = '{(prefix == 8'h3c) ? sct_pkg::KindShlEq : sct_pkg::KindShrEq,
                    sct_pkg::ErrNone, sct_pkg::out32(tbegin), 32'd3};
            n_emit = 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end else begin
            e_a = '{(prefix == 8'h3c) ? sct_pkg::KindShl : sct_pkg::KindShr,
                    sct_pkg::ErrNone, sct_pkg::out32(tbegin), 32'd2};
            n_emit = 2'd1;
            run_idle = 1'b1;
          end
        end
        sct_pkg::M_IDENT, sct_pkg::M_NUM: begin
          if (!(sct_pkg::is_digit(c) || (mode == sct_pkg::M_IDENT && sct_pkg::is_alpha(c))))
          begin
            e_a = '{(mode == sct_pkg::M_IDENT) ? sct_pkg::KindIdent : sct_pkg::KindNumber,
                    sct_pkg::ErrNone, sct_pkg::out32(tbegin),
                    sct_pkg::out32(bpos - tbegin)};
            n_emit = 2'd1;
            run_idle = 1'b1;
          end
        end
        sct_pkg::M_STR: begin
          if (c == 8'h5c) mode_next = sct_pkg::M_ESC;
          else if (c == prefix) begin
            e_a = '{(prefix == 8'h27) ? sct_pkg::KindSqStr : sct_pkg::KindDqStr,
                    sct_pkg::ErrNone, sct_pkg::out32(tbegin),
                    sct_pkg::out32(bpos + sct_pkg::pos_t'(1) - tbegin)};
            n_emit = 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end
        end
        sct_pkg::M_ESC: mode_next = sct_pkg::M_STR;
        sct_pkg::M_LINE: if (c == 8'h0a) mode_next = sct_pkg::M_IDLE;
        sct_pkg::M_BLOCK, sct_pkg::M_BSTAR, sct_pkg::M_BSLASH: begin
          // star-slash closes one level, slash-star opens one unless the depth is at NestMax
          if (mode == sct_pkg::M_BSTAR && c == 8'h2f) begin
            depth_next = (depth != '0) ? depth - sct_pkg::nest_t'(1) : depth;
            mode_next = (depth_next == '0) ? sct_pkg::M_IDLE : sct_pkg::M_BLOCK;
          end else if (mode == sct_pkg::M_BSLASH && c == 8'h2a) begin
            if (depth != sct_pkg::NestMax) depth_next = depth + sct_pkg::nest_t'(1);
            mode_next = sct_pkg::M_BLOCK;
          end else if (c == 8'h2a) mode_next = sct_pkg::M_BSTAR;
          else if (c == 8'h2f) mode_next = sct_pkg::M_BSLASH;
          else mode_next = sct_pkg::M_BLOCK;
        end
        default: ;
      endcase
      if (run_idle) begin
        // byte seen between tokens, possibly right after a token ended
        mode_next = sct_pkg::M_IDLE;
        k = sct_pkg::punct_kind(c);
        t = '0;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0a) begin
        end else if (k != 6'd0) begin
          t = '{k, sct_pkg::ErrNone, sct_pkg::out32(bpos), 32'd1};
          if (n_emit == 2'd0) e_a = t; else e_b = t;
          n_emit = n_emit + 2'd1;
        end else begin
          tbegin_next = bpos;
          if (sct_pkg::single_kind(c) != 6'd0) begin
            mode_next = sct_pkg::M_OP; prefix_next = c;
          end else if (c == 8'h27 || c == 8'h22) begin
            mode_next = sct_pkg::M_STR; prefix_next = c;
          end else if (sct_pkg::is_alpha(c)) mode_next = sct_pkg::M_IDENT;
          else if (sct_pkg::is_digit(c)) mode_next = sct_pkg::M_NUM;
          else begin
            t = '{sct_pkg::KindEof, sct_pkg::ErrUnknown, sct_pkg::out32(bpos), 32'd1};
            if (n_emit == 2'd0) e_a = t; else e_b = t;
            n_emit = n_emit + 2'd1;
            mode_next = sct_pkg::M_ERROR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sct_pkg::M_IDLE;
      prefix <= 8'd0;
      tbegin <= '0;
      bpos <= '0;
      depth <= '0;
      cbegin <= '0;
    end else if (take) begin
      mode <= mode_next;
      prefix <= prefix_next;
      tbegin <= tbegin_next;
      depth <= depth_next;
      cbegin <= cbegin_next;
      if (!(mode == sct_pkg::M_ERROR || mode == sct_pkg::M_DONE) &&
          !(end_of_input || byte_value == 8'd0))
        bpos <= bpos + sct_pkg::pos_t'(1);
    end
  end

  sct_out_queue u_queue (
    .clk(clk), .rst(rst),
    .push(take), .push_n(n_emit), .push_a(e_a), .push_b(e_b),
    .room(room),
    .head_valid(out_valid), .head(head), .head_last(last_of_run),
    .pop(!out_stall)
  );

  assign token_kind   = head.kind;
  assign error_code   = head.err;
  assign token_start  = head.start;
  assign token_length = head.len;

`ifndef NO_ASSERTIONS
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == sct_pkg::M_DONE || mode == sct_pkg::M_ERROR) |-> n_emit == 2'd0)
    else $error("token after end");
  a_err_stays: assert property (@(posedge clk) disable iff (rst)
    $past(mode == sct_pkg::M_ERROR) && !$past(rst) |-> mode == sct_pkg::M_ERROR)
    else $error("left error state");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != sct_pkg::ErrNone |-> token_kind == sct_pkg::KindEof)
    else $error("error token with kind");
`endif
endmodule
